// ===== sv/cbp_pkg.sv =====
// Package for the cubic Bezier point evaluator.
// Holds default sizes and the register file layout; no dependencies.
package cbp_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;

	// control points are stored x,y interleaved: index = 2*point + axis
	localparam int AXES       = 2;
	localparam int POINTS     = 4;
	localparam int REG_COUNT  = AXES * POINTS;
	localparam int REG_IDX_W  = $clog2(REG_COUNT);

	// operand slice width for the split multipliers
	localparam int CHUNK_BITS = 24;

endpackage

// ===== sv/cbp_lerp.sv =====
// Two-stage exact linear blend q = a*2^F + (b - a)*t for the evaluator.
// Depends on cbp_pkg for the multiplier slice width.
module cbp_lerp #(
	parameter int W = cbp_pkg::COORD_BITS_DEF,
	parameter int F = cbp_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	input  logic        [F:0]     t,
	output logic signed [W+F-1:0] q
);

	localparam int CHUNK = cbp_pkg::CHUNK_BITS;
	localparam int DW    = W + 1;
	localparam int NCH   = (DW + CHUNK - 1) / CHUNK;
	localparam int EW    = NCH * CHUNK;
	localparam int PPW   = CHUNK + F + 3;
	localparam int QW    = W + F;
	localparam int XW    = QW + PPW;

	logic signed [DW-1:0]    d;
	logic signed [EW-1:0]    dx;
	logic signed [F+1:0]     tx;
	logic signed [CHUNK:0]   op [NCH];
	logic signed [PPW-1:0]   pp_s1 [NCH];
	logic signed [W-1:0]     a_s1;
	logic signed [XW-1:0]    acc;
	logic        [QW-1:0]    q_s2;

	assign d  = DW'(b) - DW'(a);
	assign dx = EW'(d);
	assign tx = {1'b0, t};

	// low slices are unsigned, the top slice carries the sign
	always_comb begin
		for (int j = 0; j < NCH; j++) begin
			op[j] = {((j == NCH - 1) ? dx[EW-1] : 1'b0), dx[j*CHUNK +: CHUNK]};
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < NCH; j++) begin
			pp_s1[j] <= PPW'(op[j]) * PPW'(tx);
		end
		a_s1 <= a;
	end

	always_comb begin
		acc = XW'(a_s1) <<< F;
		for (int j = 0; j < NCH; j++) begin
			acc = acc + (XW'(pp_s1[j]) <<< (j * CHUNK));
		end
	end

	always_ff @(posedge clk) begin
		q_s2 <= acc[QW-1:0];
	end

	assign q = q_s2;

endmodule

// ===== sv/cubic_bezier_point.sv =====
// Cubic Bezier point evaluator, top level.
// Depends on cbp_pkg and cbp_lerp.
//
// Usage:
//  - Control points live in eight write-only registers on the wr_en /
//    wr_index / wr_data port: start x,y, relay A x,y, relay B x,y, end x,y
//    (index 0..7). Write them while no item is in flight.
//  - An item (one t_param, FRAC_BITS fraction bits, 1.0 = 1 << FRAC_BITS)
//    is taken at a clock edge with start high; busy is always low, so the
//    block takes one item every cycle. t above 1.0 is clamped to 1.0.
//  - Each item yields one point (point_x, point_y) shown for one cycle with
//    done high; points come out in input order.
//  - Evaluation is de Casteljau in three blend levels; every blend is exact
//    (no rounding until the end), which gives the same value as the
//    Bernstein weighted sum. Each level takes two stages: sliced multiplies
//    of (b - a) by t, then the add. The depth is set by these three levels
//    plus one stage for the t clamp and one for round and saturate.
//  - Rounding is to nearest with halves going up; the result saturates to
//    signed COORD_BITS.
//  - Reset clears the control points to zero and empties the pipeline.
//    The receiver has no back-pressure: results are never held.
module cubic_bezier_point #(
	parameter int COORD_BITS = cbp_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = cbp_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic        [FRAC_BITS:0]         t_param,
	input  logic                              wr_en,
	input  logic        [cbp_pkg::REG_IDX_W-1:0] wr_index,
	input  logic        [COORD_BITS-1:0]      wr_data,
	output logic                              done,
	output logic signed [COORD_BITS-1:0]      point_x,
	output logic signed [COORD_BITS-1:0]      point_y
);

	localparam int C  = COORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int SW = C + 3 * F;

	// control point registers, x,y interleaved
	logic signed [C-1:0] cfg_q [cbp_pkg::REG_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cbp_pkg::REG_COUNT; i++) begin
				cfg_q[i] <= '0;
			end
		end else if (wr_en) begin
			cfg_q[wr_index] <= wr_data;
		end
	end

	// never back-pressured
	assign busy = 1'b0;

	logic accept;
	assign accept = start & ~busy;

	// valid bits along the pipe
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// stage 1: clamp t to 1.0; t rides along for the later levels
	logic [F:0] t_s1, t_s2, t_s3, t_s4, t_s5;

	always_ff @(posedge clk) begin
		if (t_param[F]) begin
			t_s1 <= {1'b1, {F{1'b0}}};
		end else begin
			t_s1 <= t_param;
		end
		t_s2 <= t_s1;
		t_s3 <= t_s2;
		t_s4 <= t_s3;
		t_s5 <= t_s4;
	end

	logic signed [C+F-1:0]   q1 [cbp_pkg::AXES][3];
	logic signed [C+2*F-1:0] q2 [cbp_pkg::AXES][2];
	logic signed [SW-1:0]    q3 [cbp_pkg::AXES];

	for (genvar ax = 0; ax < cbp_pkg::AXES; ax++) begin : g_axis
		// level 1: control points, result at s3
		for (genvar i = 0; i < 3; i++) begin : g_l1
			cbp_lerp #(.W(C), .F(F)) u_lerp (
				.clk (clk),
				.a   (cfg_q[2*i+ax]),
				.b   (cfg_q[2*(i+1)+ax]),
				.t   (t_s1),
				.q   (q1[ax][i])
			);
		end
		// level 2: result at s5
		for (genvar i = 0; i < 2; i++) begin : g_l2
			cbp_lerp #(.W(C+F), .F(F)) u_lerp (
				.clk (clk),
				.a   (q1[ax][i]),
				.b   (q1[ax][i+1]),
				.t   (t_s3),
				.q   (q2[ax][i])
			);
		end
		// level 3: the curve point with 3F fraction bits, at s7
		cbp_lerp #(.W(C+2*F), .F(F)) u_l3 (
			.clk (clk),
			.a   (q2[ax][0]),
			.b   (q2[ax][1]),
			.t   (t_s5),
			.q   (q3[ax])
		);
	end

	// stage 8: round half up, drop 3F fraction bits, saturate
	logic signed [SW:0]  biased [cbp_pkg::AXES];
	logic signed [C:0]   rnd    [cbp_pkg::AXES];
	logic signed [C-1:0] sat    [cbp_pkg::AXES];
	logic signed [C-1:0] pt_s8  [cbp_pkg::AXES];

	always_comb begin
		for (int ax = 0; ax < cbp_pkg::AXES; ax++) begin
			biased[ax] = (SW+1)'(q3[ax]) + ((SW+1)'(1) <<< (3 * F - 1));
			rnd[ax]    = biased[ax][SW:3*F];
			if (rnd[ax][C] != rnd[ax][C-1]) begin
				sat[ax] = rnd[ax][C] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
			end else begin
				sat[ax] = rnd[ax][C-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int ax = 0; ax < cbp_pkg::AXES; ax++) begin
			pt_s8[ax] <= sat[ax];
		end
	end

	assign done    = vld_s8;
	assign point_x = pt_s8[0];
	assign point_y = pt_s8[1];

endmodule
